// ----- design/glyph_shelf_packer_unit_assert.svh -----
// Assertion macros for the glyph shelf packer checker.
// Depends on nothing; included by files that assert.
`ifndef GLYPH_SHELF_PACKER_UNIT_ASSERT_SVH
`define GLYPH_SHELF_PACKER_UNIT_ASSERT_SVH

// same-cycle implication under reset
`define GSP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define GSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/gsp_pkg.sv -----
// Shared types, constants and helpers for the glyph shelf packer.
// No dependencies.
package gsp_pkg;

    localparam int ATLAS_SIZE = 1024;
    localparam int CELL_PAD   = 1;
    localparam int UV_STEPS   = 128;
    localparam int GRID_RAW   = ATLAS_SIZE / UV_STEPS;
    localparam int GRID       = (GRID_RAW == 0) ? 1 : GRID_RAW;

    localparam int SIZE_W = 11;
    localparam int POS_W  = 12;
    localparam int SUM_W  = 13;

    localparam logic [20:0] CP_SPACE   = 21'h00020;
    localparam logic [20:0] CP_DEL     = 21'h0007F;
    localparam logic [20:0] CP_ZW_LO   = 21'h0200B;
    localparam logic [20:0] CP_ZW_HI   = 21'h0200F;
    localparam logic [20:0] CP_BIDI_LO = 21'h0202A;
    localparam logic [20:0] CP_BIDI_HI = 21'h0202E;
    localparam logic [20:0] CP_WJ      = 21'h02060;
    localparam logic [20:0] CP_BOM     = 21'h0FEFF;

    typedef enum logic [1:0] {
        ST_PLACED  = 2'd0,
        ST_NO_INK  = 2'd1,
        ST_FULL    = 2'd2,
        ST_CLEARED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        KIND_PLACE  = 2'd0,
        KIND_NO_INK = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    typedef struct packed {
        logic        mode;
        logic [20:0] code_point;
        logic [9:0]  ink_width;
        logic [9:0]  ink_height;
        logic        bitmap_empty;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [10:0] cell_x;
        logic [9:0]  cell_y;
        logic [10:0] cell_w;
        logic [10:0] cell_h;
        logic [31:0] change_count;
    } t_out;

    typedef struct packed {
        t_kind             kind;
        logic [SIZE_W-1:0] cell_w;
        logic [SIZE_W-1:0] cell_h;
    } t_work;

    function automatic logic [SIZE_W-1:0] round_cell(logic [9:0] ink);
        logic [POS_W-1:0] v;
        v = POS_W'(ink) + POS_W'(CELL_PAD) + POS_W'(GRID - 1);
        return SIZE_W'((v / POS_W'(GRID)) * POS_W'(GRID));
    endfunction

endpackage

// ----- design/gsp_front.sv -----
// Front end: classifies a request and sizes its cell.
// Depends on gsp_pkg.
module gsp_front (
    input  gsp_pkg::t_in   i_data,
    input  logic           i_valid,
    input  logic           i_q_full,
    output logic           o_ready,
    output logic           o_push,
    output gsp_pkg::t_work o_work
);

    logic no_ink_code;

    always_comb begin
        no_ink_code = i_data.code_point inside {
            [21'h0 : gsp_pkg::CP_SPACE],
            gsp_pkg::CP_DEL,
            [gsp_pkg::CP_ZW_LO : gsp_pkg::CP_ZW_HI],
            [gsp_pkg::CP_BIDI_LO : gsp_pkg::CP_BIDI_HI],
            gsp_pkg::CP_WJ,
            gsp_pkg::CP_BOM
        };
    end

    always_comb begin
        o_work.cell_w = gsp_pkg::round_cell(i_data.ink_width);
        o_work.cell_h = gsp_pkg::round_cell(i_data.ink_height);
        if (i_data.mode) begin
            o_work.kind = gsp_pkg::KIND_CLEAR;
        end else if (no_ink_code || i_data.bitmap_empty ||
                     i_data.ink_width == '0 || i_data.ink_height == '0) begin
            o_work.kind = gsp_pkg::KIND_NO_INK;
        end else begin
            o_work.kind = gsp_pkg::KIND_PLACE;
        end
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

endmodule

// ----- design/gsp_queue.sv -----
// Two-entry queue between front and back.
// Depends on gsp_pkg.
module gsp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gsp_pkg::t_work i_work,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output gsp_pkg::t_work o_work
);

    gsp_pkg::t_work r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic [1:0]     n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_work  = r_mem[r_rd_ptr];

endmodule

// ----- design/gsp_back.sv -----
// Back end: shelf state, placement and the result register.
// Depends on gsp_pkg.
module gsp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  gsp_pkg::t_work i_work,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output gsp_pkg::t_out  o_data
);

    logic [gsp_pkg::POS_W-1:0]  r_cursor_x, n_cursor_x;
    logic [gsp_pkg::SIZE_W-1:0] r_shelf_top, n_shelf_top;
    logic [gsp_pkg::SIZE_W-1:0] r_shelf_tall, n_shelf_tall;
    logic                       r_atlas_full, n_atlas_full;
    logic [31:0]                r_generation, n_generation;
    logic                       r_out_valid;
    gsp_pkg::t_out              r_out, n_out;

    logic                       wrap;
    logic                       fits;
    logic [gsp_pkg::POS_W-1:0]  pos_x;
    logic [gsp_pkg::POS_W-1:0]  top_w;
    logic [gsp_pkg::SIZE_W-1:0] tall_w;

    assign o_pop = i_q_valid && (!r_out_valid || i_ready);

    always_comb begin
        wrap   = (gsp_pkg::SUM_W'(r_cursor_x) + gsp_pkg::SUM_W'(i_work.cell_w))
                 >= gsp_pkg::SUM_W'(gsp_pkg::ATLAS_SIZE);
        pos_x  = wrap ? '0 : r_cursor_x;
        top_w  = wrap ? (gsp_pkg::POS_W'(r_shelf_top) + gsp_pkg::POS_W'(r_shelf_tall))
                      : gsp_pkg::POS_W'(r_shelf_top);
        tall_w = wrap ? '0 : r_shelf_tall;
        fits   = (gsp_pkg::SUM_W'(top_w) + gsp_pkg::SUM_W'(i_work.cell_h))
                 < gsp_pkg::SUM_W'(gsp_pkg::ATLAS_SIZE);
    end

    always_comb begin
        n_cursor_x   = r_cursor_x;
        n_shelf_top  = r_shelf_top;
        n_shelf_tall = r_shelf_tall;
        n_atlas_full = r_atlas_full;
        n_generation = r_generation;
        n_out        = '0;
        case (i_work.kind)
            gsp_pkg::KIND_CLEAR: begin
                n_cursor_x   = '0;
                n_shelf_top  = '0;
                n_shelf_tall = '0;
                n_atlas_full = 1'b0;
                n_generation = r_generation + 32'd1;
                n_out.status = gsp_pkg::ST_CLEARED;
            end
            gsp_pkg::KIND_NO_INK: begin
                n_out.status = r_atlas_full ? gsp_pkg::ST_FULL : gsp_pkg::ST_NO_INK;
            end
            gsp_pkg::KIND_PLACE: begin
                if (r_atlas_full) begin
                    n_out.status = gsp_pkg::ST_FULL;
                end else begin
                    n_cursor_x   = pos_x;
                    n_shelf_top  = gsp_pkg::SIZE_W'(top_w);
                    n_shelf_tall = tall_w;
                    if (!fits) begin
                        n_atlas_full = 1'b1;
                        n_out.status = gsp_pkg::ST_FULL;
                    end else begin
                        n_out.status = gsp_pkg::ST_PLACED;
                        n_out.cell_x = pos_x[10:0];
                        n_out.cell_y = top_w[9:0];
                        n_out.cell_w = i_work.cell_w;
                        n_out.cell_h = i_work.cell_h;
                        n_cursor_x   = pos_x + gsp_pkg::POS_W'(i_work.cell_w);
                        if (i_work.cell_h > tall_w) begin
                            n_shelf_tall = i_work.cell_h;
                        end
                        n_generation = r_generation + 32'd1;
                    end
                end
            end
            default: begin
                n_out.status = gsp_pkg::ST_NO_INK;
            end
        endcase
        n_out.change_count = n_generation;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x   <= '0;
            r_shelf_top  <= '0;
            r_shelf_tall <= '0;
            r_atlas_full <= 1'b0;
            r_generation <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cursor_x   <= n_cursor_x;
                r_shelf_top  <= n_shelf_top;
                r_shelf_tall <= n_shelf_tall;
                r_atlas_full <= n_atlas_full;
                r_generation <= n_generation;
                r_out_valid  <= 1'b1;
            end else if (i_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ----- design/glyph_shelf_packer_unit.sv -----
// Top level of the glyph shelf packer: front, queue and back.
// Depends on gsp_pkg, gsp_front, gsp_queue, gsp_back.
//
//   channel  | valid    | ready    | payload
//   ---------+----------+----------+----------------
//   request  | i_valid  | o_ready  | i_data (t_in)
//   result   | o_valid  | i_ready  | o_data (t_out)
//
// One item per cycle sustained while i_ready is high; each result passes through the queue
// and the result register. The back end's shelf update sets the rate.
// Reset is synchronous, active low; it clears the shelf state and the generation.
// The two-entry queue keeps the request side open while a result is held, until it fills.
module glyph_shelf_packer_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  gsp_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output gsp_pkg::t_out o_data
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_valid;
    gsp_pkg::t_work f_work;
    gsp_pkg::t_work q_work;

    gsp_front u_front (
        .i_data   (i_data),
        .i_valid  (i_valid),
        .i_q_full (q_full),
        .o_ready  (o_ready),
        .o_push   (q_push),
        .o_work   (f_work)
    );

    gsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_work  (f_work),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_work  (q_work)
    );

    gsp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_work    (q_work),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

endmodule

// ----- design/gsp_checker.sv -----
// Port-level checks for the glyph shelf packer, bound to the top level.
// Depends on gsp_pkg and glyph_shelf_packer_unit_assert.svh.
`include "glyph_shelf_packer_unit_assert.svh"

module gsp_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input gsp_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_ready,
    input gsp_pkg::t_out o_data
);

    `GSP_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && !o_ready,
        i_valid && $stable(i_data), "request changed while stalled")

    `GSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_data), "result changed while stalled")

    `GSP_ASSERT_SAME(a_placed_size, i_clk, i_rst_n,
        o_valid && o_data.status == gsp_pkg::ST_PLACED,
        o_data.cell_w != '0 && o_data.cell_h != '0, "placed cell has zero size")

    `GSP_ASSERT_SAME(a_unplaced_zero, i_clk, i_rst_n,
        o_valid && o_data.status != gsp_pkg::ST_PLACED,
        o_data.cell_x == '0 && o_data.cell_y == '0 && o_data.cell_w == '0 && o_data.cell_h == '0,
        "unplaced result carries a cell")

    `GSP_ASSERT_SAME(a_inside_atlas, i_clk, i_rst_n,
        o_valid && o_data.status == gsp_pkg::ST_PLACED,
        (gsp_pkg::SUM_W'(o_data.cell_y) + gsp_pkg::SUM_W'(o_data.cell_h))
            < gsp_pkg::SUM_W'(gsp_pkg::ATLAS_SIZE),
        "placed cell reaches bottom edge")

endmodule

bind glyph_shelf_packer_unit gsp_checker u_gsp_checker (.*);

// ----- bench/tb.sv -----
// Self-checking bench for glyph_shelf_packer_unit: directed and random place/clear
// requests checked against an in-bench shelf packer model, random stalls on both sides.
// Depends on gsp_pkg and the glyph_shelf_packer_unit RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          IDLE_LIMIT   = 4000;
    localparam int          RANDOM_ITEMS = 1025;
    localparam int          TAIL_CYCLES  = 20;
    localparam int          MAX_REPORTS  = 10;
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    gsp_pkg::t_in  i_data;
    logic          o_valid;
    logic          i_ready;
    gsp_pkg::t_out o_data;

    glyph_shelf_packer_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // packer model state
    logic [11:0] pk_cursor;
    logic [10:0] pk_top;
    logic [10:0] pk_tall;
    logic        pk_full;
    logic [31:0] pk_gen;

    gsp_pkg::t_out cell_q[$];
    int            mismatches;
    int            sent;
    int            status_seen[4];
    bit            steady;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic int round_up_grid(int v);
        return ((v + gsp_pkg::GRID - 1) / gsp_pkg::GRID) * gsp_pkg::GRID;
    endfunction

    function automatic bit is_blank_code(logic [20:0] cp);
        return cp <= gsp_pkg::CP_SPACE || cp == gsp_pkg::CP_DEL
            || (cp >= gsp_pkg::CP_ZW_LO && cp <= gsp_pkg::CP_ZW_HI)
            || (cp >= gsp_pkg::CP_BIDI_LO && cp <= gsp_pkg::CP_BIDI_HI)
            || cp == gsp_pkg::CP_WJ || cp == gsp_pkg::CP_BOM;
    endfunction

    function automatic gsp_pkg::t_out pack_glyph(gsp_pkg::t_in req);
        gsp_pkg::t_out res;
        int            nw;
        int            nh;
        res = '0;
        if (req.mode) begin
            pk_cursor  = '0;
            pk_top     = '0;
            pk_tall    = '0;
            pk_full    = 1'b0;
            pk_gen     = pk_gen + 32'd1;
            res.status = gsp_pkg::ST_CLEARED;
        end else if (pk_full) begin
            res.status = gsp_pkg::ST_FULL;
        end else if (is_blank_code(req.code_point) || req.bitmap_empty
                     || req.ink_width == '0 || req.ink_height == '0) begin
            res.status = gsp_pkg::ST_NO_INK;
        end else begin
            nw = round_up_grid(int'(req.ink_width) + gsp_pkg::CELL_PAD);
            nh = round_up_grid(int'(req.ink_height) + gsp_pkg::CELL_PAD);
            if (int'(pk_cursor) + nw >= gsp_pkg::ATLAS_SIZE) begin
                pk_top    = pk_top + pk_tall;
                pk_tall   = '0;
                pk_cursor = '0;
            end
            if (int'(pk_top) + nh >= gsp_pkg::ATLAS_SIZE) begin
                pk_full    = 1'b1;
                res.status = gsp_pkg::ST_FULL;
            end else begin
                res.cell_x = 11'(pk_cursor);
                res.cell_y = 10'(pk_top);
                res.cell_w = 11'(nw);
                res.cell_h = 11'(nh);
                pk_cursor  = pk_cursor + 12'(nw);
                if (nh > int'(pk_tall)) begin
                    pk_tall = 11'(nh);
                end
                pk_gen     = pk_gen + 32'd1;
                res.status = gsp_pkg::ST_PLACED;
            end
        end
        res.change_count = pk_gen;
        return res;
    endfunction

    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return $urandom_range(0, 2);
        if (p < 92) return $urandom_range(3, 8);
        return $urandom_range(12, 40);
    endfunction

    function automatic gsp_pkg::t_in make_req(bit mode, logic [20:0] cp, int w, int h,
                                              bit empty);
        gsp_pkg::t_in r;
        r.mode         = mode;
        r.code_point   = cp;
        r.ink_width    = 10'(w);
        r.ink_height   = 10'(h);
        r.bitmap_empty = empty;
        return r;
    endfunction

    function automatic int random_ink();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return $urandom_range(1, 64);
        if (p < 90) return $urandom_range(65, 256);
        return $urandom_range(0, 1023);
    endfunction

    function automatic logic [20:0] blank_code();
        case ($urandom_range(0, 5))
            0: return 21'($urandom_range(0, int'(gsp_pkg::CP_SPACE)));
            1: return gsp_pkg::CP_DEL;
            2: return 21'($urandom_range(int'(gsp_pkg::CP_ZW_LO), int'(gsp_pkg::CP_ZW_HI)));
            3: return 21'($urandom_range(int'(gsp_pkg::CP_BIDI_LO),
                                         int'(gsp_pkg::CP_BIDI_HI)));
            4: return gsp_pkg::CP_WJ;
            default: return gsp_pkg::CP_BOM;
        endcase
    endfunction

    function automatic gsp_pkg::t_in random_req();
        int p;
        p = $urandom_range(0, 99);
        if (p < 2) begin
            return make_req(1'b1, 21'($urandom_range(0, int'(CP_MAX))),
                            $urandom_range(0, 1023), $urandom_range(0, 1023),
                            1'($urandom_range(0, 1)));
        end
        if (p < 12) begin
            case ($urandom_range(0, 3))
                0: return make_req(1'b0, blank_code(), random_ink(), random_ink(), 1'b0);
                1: return make_req(1'b0, 21'($urandom_range(0, int'(CP_MAX))),
                                   random_ink(), random_ink(), 1'b1);
                2: return make_req(1'b0, 21'($urandom_range(0, int'(CP_MAX))),
                                   0, random_ink(), 1'b0);
                default: return make_req(1'b0, 21'($urandom_range(0, int'(CP_MAX))),
                                         random_ink(), 0, 1'b0);
            endcase
        end
        return make_req(1'b0, 21'($urandom_range(int'(gsp_pkg::CP_SPACE) + 1, int'(CP_MAX))),
                        random_ink(), random_ink(), 1'b0);
    endfunction

    // one request transfer; called and returns at a falling edge
    task automatic send_item(gsp_pkg::t_in req);
        i_data  = req;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        cell_q.push_back(pack_glyph(req));
        sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
        if (!steady) begin
            repeat (idle_len()) @(negedge i_clk);
        end
    endtask

    task automatic test_clear();
        send_item(make_req(1'b1, 21'h0, 0, 0, 1'b0));
    endtask

    task automatic test_no_ink();
        send_item(make_req(1'b0, 21'h0, 5, 5, 1'b0));
        send_item(make_req(1'b0, gsp_pkg::CP_SPACE, 5, 5, 1'b0));
        send_item(make_req(1'b0, gsp_pkg::CP_DEL, 5, 5, 1'b0));
        send_item(make_req(1'b0, gsp_pkg::CP_ZW_LO, 5, 5, 1'b0));
        send_item(make_req(1'b0, gsp_pkg::CP_ZW_HI, 5, 5, 1'b0));
        send_item(make_req(1'b0, gsp_pkg::CP_BIDI_LO, 5, 5, 1'b0));
        send_item(make_req(1'b0, gsp_pkg::CP_BIDI_HI, 5, 5, 1'b0));
        send_item(make_req(1'b0, gsp_pkg::CP_WJ, 5, 5, 1'b0));
        send_item(make_req(1'b0, gsp_pkg::CP_BOM, 5, 5, 1'b0));
        send_item(make_req(1'b0, 21'h41, 5, 5, 1'b1));
        send_item(make_req(1'b0, 21'h41, 0, 5, 1'b0));
        send_item(make_req(1'b0, 21'h41, 5, 0, 1'b0));
    endtask

    task automatic test_extremes();
        send_item(make_req(1'b0, gsp_pkg::CP_SPACE + 21'd1, 1, 1, 1'b0));
        send_item(make_req(1'b0, CP_MAX, 1023, 1, 1'b0));
        send_item(make_req(1'b0, gsp_pkg::CP_DEL - 21'd1, 9, 9, 1'b0));
        send_item(make_req(1'b0, gsp_pkg::CP_ZW_LO - 21'd1, 7, 40, 1'b0));
        send_item(make_req(1'b0, gsp_pkg::CP_ZW_HI + 21'd1, 500, 200, 1'b0));
    endtask

    task automatic test_fill_to_full();
        send_item(make_req(1'b0, 21'h41, 1023, 1023, 1'b0));
        send_item(make_req(1'b0, 21'h42, 5, 5, 1'b0));
        send_item(make_req(1'b0, gsp_pkg::CP_SPACE, 5, 5, 1'b0));
        send_item(make_req(1'b1, CP_MAX, 1023, 1023, 1'b1));
        send_item(make_req(1'b0, 21'h43, 1, 1014, 1'b0));
    endtask

    task automatic test_random();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            steady = ((i % 256) < 48);
            send_item(random_req());
        end
        steady = 1'b0;
    endtask

    initial begin : result_sink
        int hold;
        i_ready = 1'b0;
        hold    = 0;
        forever begin
            @(negedge i_clk);
            if (steady) begin
                i_ready = 1'b1;
            end else if (hold > 0) begin
                hold--;
            end else begin
                i_ready = ($urandom_range(0, 3) != 0);
                hold    = idle_len();
            end
        end
    end

    initial begin : result_check
        gsp_pkg::t_out exp;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (cell_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected result: %p", o_data);
                    end
                end else begin
                    exp = cell_q.pop_front();
                    status_seen[exp.status]++;
                    if (o_data.status !== exp.status || o_data.cell_x !== exp.cell_x
                        || o_data.cell_y !== exp.cell_y || o_data.cell_w !== exp.cell_w
                        || o_data.cell_h !== exp.cell_h
                        || o_data.change_count !== exp.change_count) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("mismatch: exp st=%0d x=%0d y=%0d w=%0d h=%0d gen=%0d",
                                     exp.status, exp.cell_x, exp.cell_y, exp.cell_w,
                                     exp.cell_h, exp.change_count);
                            $display("          got st=%0d x=%0d y=%0d w=%0d h=%0d gen=%0d",
                                     o_data.status, o_data.cell_x, o_data.cell_y,
                                     o_data.cell_w, o_data.cell_h, o_data.change_count);
                        end
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        wait (i_rst_n);
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("stalled: no transfer for %0d cycles", IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_data     = '0;
        steady     = 1'b0;
        mismatches = 0;
        sent       = 0;
        status_seen = '{default: 0};
        pk_cursor  = '0;
        pk_top     = '0;
        pk_tall    = '0;
        pk_full    = 1'b0;
        pk_gen     = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_clear();
        test_no_ink();
        test_extremes();
        test_fill_to_full();
        test_random();

        while (cell_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d requests: %0d placed, %0d no-ink, %0d refused, %0d clears",
                 sent, status_seen[gsp_pkg::ST_PLACED], status_seen[gsp_pkg::ST_NO_INK],
                 status_seen[gsp_pkg::ST_FULL], status_seen[gsp_pkg::ST_CLEARED]);
        $display("%0d mismatches, %0d results never seen", mismatches, cell_q.size());
        if (mismatches == 0 && cell_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
